// File: src/cfa_pkg.sv
`default_nettype none

package cfa_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int SUM_W         = PROD_W + 1;
  localparam int RND_W         = SUM_W + 1;
  localparam int RES_W         = 32;
  localparam int SHL_MAX       = RES_W - 1;
  localparam int WIDE_W        = RND_W + SHL_MAX;

  localparam int IN_FRAC_W     = 4;
  localparam int COEF_FRAC_W   = 4;
  localparam int OUT_TOTAL_W   = 6;
  localparam int OUT_FRAC_W    = 5;
  localparam int SF_W          = IN_FRAC_W + 1;
  localparam int SHIFT_W       = OUT_FRAC_W;

  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_IDX_LSB   = 2;

  localparam logic [OUT_TOTAL_W-1:0] OUT_TOTAL_MIN = OUT_TOTAL_W'(2);
  localparam logic [OUT_TOTAL_W-1:0] OUT_TOTAL_MAX = OUT_TOTAL_W'(RES_W);

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_SUB     = 3'd1,
    ACT_MUL     = 3'd2,
    ACT_CONJ    = 3'd3,
    ACT_SCALE   = 3'd4,
    ACT_REQUANT = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    REG_IN_FRAC   = 3'd0,
    REG_COEF_FRAC = 3'd1,
    REG_OUT_TOTAL = 3'd2,
    REG_OUT_FRAC  = 3'd3,
    REG_ROUND_EN  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [IN_FRAC_W-1:0]   in_frac;
    logic [COEF_FRAC_W-1:0] coef_frac;
    logic [OUT_TOTAL_W-1:0] out_total;
    logic [OUT_FRAC_W-1:0]  out_frac;
    logic                   round_en;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/cfa_operand_if.sv
`default_nettype none

interface cfa_operand_if;
  import cfa_pkg::*;

  logic                            valid;
  logic                            ready;
  logic [2:0]                      action;
  logic signed [OPERAND_WIDTH-1:0] a_real;
  logic signed [OPERAND_WIDTH-1:0] a_imag;
  logic signed [OPERAND_WIDTH-1:0] b_real;
  logic signed [OPERAND_WIDTH-1:0] b_imag;

  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, action, a_real, a_imag, b_real, b_imag, output ready);

endinterface

`default_nettype wire

// File: src/cfa_result_if.sv
`default_nettype none

interface cfa_result_if;
  import cfa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] res_real;
  logic signed [RES_W-1:0] res_imag;
  logic                    clipped;

  modport source (output valid, res_real, res_imag, clipped, input ready);
  modport sink (input valid, res_real, res_imag, clipped, output ready);

endinterface

`default_nettype wire

// File: src/complex_fixed_point_alu.sv
// Complex fixed-point unit: add, subtract, complex multiply, conjugate, real scale or
// requantize of signed complex operands, each result part shifted to the output
// fraction width, optionally rounded by half an LSB, floored and saturated to the
// output total width, with clipped set when either part saturates. Fully pipelined:
// one beat per cycle while the result is taken; each beat passes through the multiply,
// combine, round, and shift and saturate registers. A stalled result back-pressures
// stage by stage, so empty stages still take new beats. Registers must be written
// over the APB port only while no beat is in flight; the block does not enforce it.
`default_nettype none

module complex_fixed_point_alu (
  input  wire logic                           clk,
  input  wire logic                           rst,
  cfa_operand_if.sink                         operand,
  cfa_result_if.source                        result,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cfa_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [cfa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [cfa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import cfa_pkg::*;

  cfg_t                    cfg;
  logic                    x_valid;
  logic                    x_ready;
  logic signed [SUM_W-1:0] x_real;
  logic signed [SUM_W-1:0] x_imag;
  logic [SF_W-1:0]         x_sf;

  cfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .cfg     (cfg),
    .x_valid (x_valid),
    .x_ready (x_ready),
    .x_real  (x_real),
    .x_imag  (x_imag),
    .x_sf    (x_sf)
  );

  cfa_requant u_requant (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .x_valid (x_valid),
    .x_ready (x_ready),
    .x_real  (x_real),
    .x_imag  (x_imag),
    .x_sf    (x_sf),
    .result  (result)
  );

endmodule

`default_nettype wire

// File: src/cfa_cfg.sv
`default_nettype none

module cfa_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cfa_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [cfa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [cfa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output cfa_pkg::cfg_t                       cfg
);
  import cfa_pkg::*;

  reg_index_t idx;

  assign idx    = reg_index_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_frac   <= IN_FRAC_W'(8);
      cfg.coef_frac <= COEF_FRAC_W'(8);
      cfg.out_total <= OUT_TOTAL_W'(16);
      cfg.out_frac  <= OUT_FRAC_W'(8);
      cfg.round_en  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_IN_FRAC:   cfg.in_frac   <= pwdata[IN_FRAC_W-1:0];
        REG_COEF_FRAC: cfg.coef_frac <= pwdata[COEF_FRAC_W-1:0];
        REG_OUT_TOTAL: cfg.out_total <= pwdata[OUT_TOTAL_W-1:0];
        REG_OUT_FRAC:  cfg.out_frac  <= pwdata[OUT_FRAC_W-1:0];
        REG_ROUND_EN:  cfg.round_en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_IN_FRAC:   prdata = CFG_DATA_W'(cfg.in_frac);
      REG_COEF_FRAC: prdata = CFG_DATA_W'(cfg.coef_frac);
      REG_OUT_TOTAL: prdata = CFG_DATA_W'(cfg.out_total);
      REG_OUT_FRAC:  prdata = CFG_DATA_W'(cfg.out_frac);
      REG_ROUND_EN:  prdata = CFG_DATA_W'(cfg.round_en);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/cfa_front.sv
`default_nettype none

module cfa_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  cfa_operand_if.sink                          operand,
  input  wire cfa_pkg::cfg_t                   cfg,
  output logic                                 x_valid,
  input  wire logic                            x_ready,
  output logic signed [cfa_pkg::SUM_W-1:0]     x_real,
  output logic signed [cfa_pkg::SUM_W-1:0]     x_imag,
  output logic        [cfa_pkg::SF_W-1:0]      x_sf
);
  import cfa_pkg::*;

  logic                     s1_valid;
  logic                     s1_ready;
  logic                     s2_ready;
  logic signed [PROD_W-1:0] p0, p1, p2, p3;
  logic signed [PROD_W-1:0] p0_next, p1_next, p2_next, p3_next;
  logic        [SF_W-1:0]   s1_sf, sf_next;
  logic signed [PROD_W-1:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [PROD_W-1:0] ar, ai, br, bi;

  assign s2_ready      = !x_valid || x_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign operand.ready = s1_ready;

  assign m_rr = operand.a_real * operand.b_real;
  assign m_ii = operand.a_imag * operand.b_imag;
  assign m_ri = operand.a_real * operand.b_imag;
  assign m_ir = operand.a_imag * operand.b_real;

  assign ar = PROD_W'(operand.a_real);
  assign ai = PROD_W'(operand.a_imag);
  assign br = PROD_W'(operand.b_real);
  assign bi = PROD_W'(operand.b_imag);

  always_comb begin
    p0_next = '0;
    p1_next = '0;
    p2_next = '0;
    p3_next = '0;
    sf_next = SF_W'(cfg.in_frac);
    case (action_t'(operand.action))
      ACT_ADD: begin
        p0_next = ar;
        p1_next = -br;
        p2_next = ai;
        p3_next = bi;
      end
      ACT_SUB: begin
        p0_next = ar;
        p1_next = br;
        p2_next = ai;
        p3_next = -bi;
      end
      ACT_MUL: begin
        p0_next = m_rr;
        p1_next = m_ii;
        p2_next = m_ri;
        p3_next = m_ir;
        sf_next = {cfg.in_frac, 1'b0};
      end
      ACT_CONJ: begin
        p0_next = ar;
        p2_next = -ai;
      end
      ACT_SCALE: begin
        p0_next = m_rr;
        p3_next = m_ir;
        sf_next = SF_W'(cfg.in_frac) + SF_W'(cfg.coef_frac);
      end
      ACT_REQUANT: begin
        p0_next = ar;
        p2_next = ai;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= operand.valid;
    end
    if (s1_ready) begin
      p0    <= p0_next;
      p1    <= p1_next;
      p2    <= p2_next;
      p3    <= p3_next;
      s1_sf <= sf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (s2_ready) begin
      x_valid <= s1_valid;
    end
    if (s2_ready) begin
      x_real <= SUM_W'(p0) - SUM_W'(p1);
      x_imag <= SUM_W'(p2) + SUM_W'(p3);
      x_sf   <= s1_sf;
    end
  end

  a_mul_frac: assert property (@(posedge clk) disable iff (rst)
    operand.valid && operand.ready && operand.action == ACT_MUL
    |=> s1_valid && s1_sf == $past({cfg.in_frac, 1'b0}))
    else $error("product beat lost its doubled fraction width");

endmodule

`default_nettype wire

// File: src/cfa_requant.sv
`default_nettype none

module cfa_requant (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cfa_pkg::cfg_t               cfg,
  input  wire logic                        x_valid,
  output logic                             x_ready,
  input  wire logic signed [cfa_pkg::SUM_W-1:0] x_real,
  input  wire logic signed [cfa_pkg::SUM_W-1:0] x_imag,
  input  wire logic        [cfa_pkg::SF_W-1:0]  x_sf,
  cfa_result_if.source                     result
);
  import cfa_pkg::*;

  logic                      left;
  logic [SHIFT_W-1:0]        d;
  logic signed [RND_W-1:0]   half;
  logic                      s3_valid;
  logic                      s3_ready;
  logic                      s4_ready;
  logic signed [RND_W-1:0]   y_real, y_imag;
  logic                      s3_left;
  logic [SHIFT_W-1:0]        s3_d;
  logic [OUT_TOTAL_W-1:0]    t_eff;
  logic signed [WIDE_W-1:0]  hi, lo;
  logic signed [WIDE_W-1:0]  w_real, w_imag;
  logic signed [RES_W-1:0]   q_real, q_imag;
  logic                      c_real, c_imag;

  assign s4_ready = !result.valid || result.ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign x_ready  = s3_ready;

  assign left = cfg.out_frac >= OUT_FRAC_W'(x_sf);
  assign d    = left ? (cfg.out_frac - OUT_FRAC_W'(x_sf))
                     : (OUT_FRAC_W'(x_sf) - cfg.out_frac);
  assign half = (cfg.round_en && !left) ? (RND_W'(1) << (d - SHIFT_W'(1))) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= x_valid;
    end
    if (s3_ready) begin
      y_real  <= RND_W'(x_real) + half;
      y_imag  <= RND_W'(x_imag) + half;
      s3_left <= left;
      s3_d    <= d;
    end
  end

  always_comb begin
    if (cfg.out_total < OUT_TOTAL_MIN) begin
      t_eff = OUT_TOTAL_MIN;
    end else if (cfg.out_total > OUT_TOTAL_MAX) begin
      t_eff = OUT_TOTAL_MAX;
    end else begin
      t_eff = cfg.out_total;
    end
    hi = (WIDE_W'(1) <<< (t_eff - OUT_TOTAL_W'(1))) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);

    w_real = s3_left ? (WIDE_W'(y_real) <<< s3_d) : (WIDE_W'(y_real) >>> s3_d);
    w_imag = s3_left ? (WIDE_W'(y_imag) <<< s3_d) : (WIDE_W'(y_imag) >>> s3_d);

    c_real = 1'b1;
    if (w_real > hi) begin
      q_real = hi[RES_W-1:0];
    end else if (w_real < lo) begin
      q_real = lo[RES_W-1:0];
    end else begin
      q_real = w_real[RES_W-1:0];
      c_real = 1'b0;
    end

    c_imag = 1'b1;
    if (w_imag > hi) begin
      q_imag = hi[RES_W-1:0];
    end else if (w_imag < lo) begin
      q_imag = lo[RES_W-1:0];
    end else begin
      q_imag = w_imag[RES_W-1:0];
      c_imag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s4_ready) begin
      result.valid <= s3_valid;
    end
    if (s4_ready) begin
      result.res_real <= q_real;
      result.res_imag <= q_imag;
      result.clipped  <= c_real || c_imag;
    end
  end

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> WIDE_W'(result.res_real) <= hi && WIDE_W'(result.res_real) >= lo
                  && WIDE_W'(result.res_imag) <= hi && WIDE_W'(result.res_imag) >= lo)
    else $error("result outside the output format");

  a_trunc_pass: assert property (@(posedge clk) disable iff (rst)
    x_valid && x_ready && !cfg.round_en
    |=> s3_valid && y_real == $past(RND_W'(x_real)) && y_imag == $past(RND_W'(x_imag)))
    else $error("rounding offset added with rounding off");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !s3_ready |=> s3_valid && $stable(y_real) && $stable(y_imag) && $stable(s3_d))
    else $error("stalled beat changed in rounding stage");

endmodule

`default_nettype wire

// File: test/complex_fixed_point_alu_tb.sv
`default_nettype none

module complex_fixed_point_alu_tb;
  import cfa_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [2:0] ACT_LIST [8] = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_CONJ, ACT_SCALE,
                                          ACT_REQUANT, ACT_SPARE_LO, ACT_SPARE_HI};
  localparam logic signed [OPERAND_WIDTH-1:0] OP_MAX = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
  localparam logic signed [OPERAND_WIDTH-1:0] OP_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic signed [RES_W-1:0] re;
    logic signed [RES_W-1:0] im;
    logic                    clip;
  } cplx_result_t;

  class cplx_result_tracker;
    int unsigned  in_frac;
    int unsigned  coef_frac;
    int unsigned  out_total;
    int unsigned  out_frac;
    bit           round_en;
    bit           part_sat;
    cplx_result_t awaited_results[$];
    int           errors;
    int           beats_checked;
    int           saturated;

    function new();
      in_frac       = 8;
      coef_frac     = 8;
      out_total     = 16;
      out_frac      = 8;
      round_en      = 0;
      errors        = 0;
      beats_checked = 0;
      saturated     = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IN_FRAC:   in_frac   = data[IN_FRAC_W-1:0];
        REG_COEF_FRAC: coef_frac = data[COEF_FRAC_W-1:0];
        REG_OUT_TOTAL: out_total = data[OUT_TOTAL_W-1:0];
        REG_OUT_FRAC:  out_frac  = data[OUT_FRAC_W-1:0];
        REG_ROUND_EN:  round_en  = data[0];
        default: ;
      endcase
    endfunction

    function longint requantize(longint v, int unsigned sf);
      int unsigned t;
      int unsigned d;
      longint      hi;
      longint      lo;
      longint      lim_hi;
      longint      lim_lo;
      longint      half;
      longint      q;
      t  = (out_total < 2) ? 2 : ((out_total > RES_W) ? RES_W : out_total);
      hi = (longint'(1) << (t - 1)) - 1;
      lo = -(longint'(1) << (t - 1));
      if (out_frac >= sf) begin
        d      = out_frac - sf;
        lim_hi = hi >>> d;
        lim_lo = -((longint'(1) << (t - 1)) >>> d);
        if (v > lim_hi) begin
          part_sat = 1;
          return hi;
        end
        if (v < lim_lo) begin
          part_sat = 1;
          return lo;
        end
        return v <<< d;
      end
      d    = sf - out_frac;
      half = round_en ? (longint'(1) << (d - 1)) : longint'(0);
      q    = (v + half) >>> d;
      if (q > hi) begin
        part_sat = 1;
        return hi;
      end
      if (q < lo) begin
        part_sat = 1;
        return lo;
      end
      return q;
    endfunction

    function cplx_result_t predict_result(logic [2:0] act,
                                          logic signed [OPERAND_WIDTH-1:0] ar,
                                          logic signed [OPERAND_WIDTH-1:0] ai,
                                          logic signed [OPERAND_WIDTH-1:0] br,
                                          logic signed [OPERAND_WIDTH-1:0] bi);
      longint       xr;
      longint       xi;
      longint       qr;
      longint       qi;
      int unsigned  sf;
      cplx_result_t r;
      r        = '0;
      part_sat = 0;
      sf       = in_frac;
      xr       = 0;
      xi       = 0;
      case (act)
        ACT_ADD: begin
          xr = longint'(ar) + longint'(br);
          xi = longint'(ai) + longint'(bi);
        end
        ACT_SUB: begin
          xr = longint'(ar) - longint'(br);
          xi = longint'(ai) - longint'(bi);
        end
        ACT_MUL: begin
          xr = longint'(ar) * longint'(br) - longint'(ai) * longint'(bi);
          xi = longint'(ar) * longint'(bi) + longint'(ai) * longint'(br);
          sf = 2 * in_frac;
        end
        ACT_CONJ: begin
          xr = longint'(ar);
          xi = -longint'(ai);
        end
        ACT_SCALE: begin
          xr = longint'(ar) * longint'(br);
          xi = longint'(ai) * longint'(br);
          sf = in_frac + coef_frac;
        end
        ACT_REQUANT: begin
          xr = longint'(ar);
          xi = longint'(ai);
        end
        default: return r;
      endcase
      qr     = requantize(xr, sf);
      qi     = requantize(xi, sf);
      r.re   = qr[RES_W-1:0];
      r.im   = qi[RES_W-1:0];
      r.clip = part_sat;
      return r;
    endfunction

    function void note_operands(logic [2:0] act,
                                logic signed [OPERAND_WIDTH-1:0] ar,
                                logic signed [OPERAND_WIDTH-1:0] ai,
                                logic signed [OPERAND_WIDTH-1:0] br,
                                logic signed [OPERAND_WIDTH-1:0] bi);
      cplx_result_t r;
      r = predict_result(act, ar, ai, br, bi);
      if (r.clip) saturated++;
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic signed [RES_W-1:0] re, logic signed [RES_W-1:0] im,
                               logic clip);
      cplx_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: re %0d im %0d clipped %b", re, im, clip);
        return;
      end
      want = awaited_results.pop_front();
      beats_checked++;
      if (re !== want.re || im !== want.im || clip !== want.clip) begin
        errors++;
        if (errors <= 10)
          $display("beat %0d mismatch: re exp %0d got %0d, im exp %0d got %0d, clip exp %b got %b",
                   beats_checked, want.re, re, want.im, im, want.clip, clip);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    hold_req = 0;
  int                    setting_count = 0;
  cplx_result_tracker    tracker;

  cfa_operand_if operand_bus ();
  cfa_result_if  result_bus ();

  complex_fixed_point_alu dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("complex_fixed_point_alu verification failed");
    $finish;
  end

  function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return OP_MAX;
      1: return OP_MIN;
      2: return '0;
      3: return '1;
      4: return OPERAND_WIDTH'($urandom_range(0, 511)) - OPERAND_WIDTH'(256);
      default: return OPERAND_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(0, 39);
    return (r < 38) ? ACT_LIST[r % 6] : ACT_LIST[r - 32];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] fill,
                                                       int unsigned value, int w);
    return (fill & ~((CFG_DATA_W'(1) << w) - 1)) | CFG_DATA_W'(value);
  endfunction

  task automatic cfg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1;
    penable = 0;
    pwrite  = 1;
    paddr   = CFG_ADDR_W'(idx) << CFG_IDX_LSB;
    pwdata  = data;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    tracker.set_register(idx, data);
    @(negedge clk);
    psel    = 0;
    penable = 0;
    pwrite  = 0;
  endtask

  task automatic apply_setting(int unsigned inf, int unsigned coef, int unsigned total,
                               int unsigned outf, int unsigned rnd, bit junk);
    logic [CFG_DATA_W-1:0] fill;
    fill = junk ? CFG_DATA_W'($urandom) : '0;
    cfg_write(REG_IN_FRAC, with_noise(fill, inf, IN_FRAC_W));
    cfg_write(REG_COEF_FRAC, with_noise(fill, coef, COEF_FRAC_W));
    cfg_write(REG_OUT_TOTAL, with_noise(fill, total, OUT_TOTAL_W));
    cfg_write(REG_OUT_FRAC, with_noise(fill, outf, OUT_FRAC_W));
    cfg_write(REG_ROUND_EN, with_noise(fill, rnd, 1));
    setting_count++;
  endtask

  task automatic send_beat(logic [2:0] act,
                           logic signed [OPERAND_WIDTH-1:0] ar,
                           logic signed [OPERAND_WIDTH-1:0] ai,
                           logic signed [OPERAND_WIDTH-1:0] br,
                           logic signed [OPERAND_WIDTH-1:0] bi);
    @(negedge clk);
    operand_bus.valid  = 1;
    operand_bus.action = act;
    operand_bus.a_real = ar;
    operand_bus.a_imag = ai;
    operand_bus.b_real = br;
    operand_bus.b_imag = bi;
    @(posedge clk);
    while (operand_bus.ready !== 1'b1) @(posedge clk);
    tracker.note_operands(act, ar, ai, br, bi);
  endtask

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      operand_bus.valid = 0;
    end
  endtask

  task automatic drain();
    pause_sender(1);
    while (tracker.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n, bit gaps, int hold_at);
    int burst_left;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = HOLD_CYCLES;
      if (gaps && burst_left == 0) begin
        pause_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      send_beat(pick_action(), pick_operand(), pick_operand(), pick_operand(), pick_operand());
      if (burst_left > 0) burst_left--;
    end
  endtask

  initial begin : receiver
    int hold_left;
    int seg_left;
    int mode;
    hold_left        = 0;
    seg_left         = 0;
    mode             = 0;
    result_bus.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      if (hold_left > 0) begin
        result_bus.ready = 0;
        hold_left--;
      end else begin
        case (mode)
          0: result_bus.ready = 1;
          1: result_bus.ready = $urandom_range(0, 1);
          2: result_bus.ready = ($urandom_range(0, 3) != 0);
          default: result_bus.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin : monitor
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        tracker.check_result(result_bus.res_real, result_bus.res_imag, result_bus.clipped);
    end
  end

  initial begin : main_seq
    rst                = 1;
    psel               = 0;
    penable            = 0;
    pwrite             = 0;
    paddr              = '0;
    pwdata             = '0;
    operand_bus.valid  = 0;
    operand_bus.action = ACT_ADD;
    operand_bus.a_real = '0;
    operand_bus.a_imag = '0;
    operand_bus.b_real = '0;
    operand_bus.b_imag = '0;
    tracker            = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_beat(ACT_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
    send_beat(ACT_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
    send_beat(ACT_ADD, '0, '0, '0, '0);
    send_beat(ACT_SUB, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
    send_beat(ACT_SUB, '1, 16'sd1, 16'sd1, '1);
    send_beat(ACT_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
    send_beat(ACT_MUL, OP_MAX, OP_MIN, OP_MAX, OP_MAX);
    send_beat(ACT_MUL, 16'sh0100, 16'sh0080, 16'sh0100, -16'sh0080);
    send_beat(ACT_MUL, '1, '1, 16'sd1, '1);
    send_beat(ACT_CONJ, 16'sh1234, OP_MIN, OP_MAX, OP_MAX);
    send_beat(ACT_CONJ, OP_MAX, OP_MAX, '0, '0);
    send_beat(ACT_SCALE, OP_MAX, OP_MIN, OP_MIN, OP_MAX);
    send_beat(ACT_SCALE, '1, 16'sd1, 16'sh0180, '0);
    send_beat(ACT_SCALE, 16'sh00ff, -16'sh00ff, 16'sh0080, OP_MIN);
    send_beat(ACT_REQUANT, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
    send_beat(ACT_REQUANT, '1, 16'sd1, '0, '0);
    send_beat(ACT_SPARE_LO, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
    send_beat(ACT_SPARE_HI, OP_MIN, '1, 16'sh5a5a, -16'sh5a5a);
    drain();

    for (int p = 0; p < 11; p++) begin
      case (p)
        0: apply_setting(0, 0, 2, 0, 1, 0);
        1: apply_setting(15, 15, 32, 31, 0, 0);
        2: apply_setting(15, 15, 32, 0, 1, 0);
        3: apply_setting(0, 15, 0, 31, 1, 0);
        4: apply_setting(8, 4, 63, 4, 0, 0);
        5: apply_setting(4, 12, 33, 20, 1, 0);
        default: apply_setting($urandom_range(0, 15), $urandom_range(0, 15),
                               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(2, 32),
                               $urandom_range(0, 31), $urandom_range(0, 1), 1);
      endcase
      run_random(100, (p % 3) != 0, (p == 1 || p == 6) ? 10 : -1);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("checked %0d result beats over the reset setting and %0d register settings",
             tracker.beats_checked, setting_count);
    $display("%0d beats expected to saturate, %0d errors", tracker.saturated, tracker.errors);
    if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
      $display("complex_fixed_point_alu verification clean");
    end else begin
      $display("complex_fixed_point_alu verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: complex_fixed_point_alu.f
src/cfa_pkg.sv
src/cfa_operand_if.sv
src/cfa_result_if.sv
src/cfa_cfg.sv
src/cfa_front.sv
src/cfa_requant.sv
src/complex_fixed_point_alu.sv
test/complex_fixed_point_alu_tb.sv
